// ===== hdl/hash_keyed_intern_table_unit_assert.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef HASH_KEYED_INTERN_TABLE_UNIT_ASSERT_SVH
`define HASH_KEYED_INTERN_TABLE_UNIT_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define HKIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define HKIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hkit_pkg.sv =====
// types, constants and status codes of the intern table
// no dependencies
package hkit_pkg;

    localparam int SLOT_COUNT_DEF  = 1024;
    localparam int LENGTH_BITS_DEF = 16;

    localparam int HASH_W       = 64;
    localparam int KEY_LEN_W    = 16;
    localparam int SLOT_INDEX_W = 10;
    localparam int LOAD_LIMIT_W = 11;

    localparam logic [LOAD_LIMIT_W-1:0] LOAD_LIMIT_RST = 11'd768;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_ZERO_LEN = 2'd1;
    localparam t_status ST_FULL     = 2'd2;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic mod_step;
        logic rd_home;
        logic rd_next;
        logic insert;
        logic fin_hit;
        logic fin_ins;
        logic fin_full;
        logic fin_zero;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic len_zero;
        logic mod_done;
        logic slot_empty;
        logic slot_hit;
        logic probe_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hdl/hkit_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module hkit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/hkit_ctrl.sv =====
// controller state machine: clearing pass, home slot, probe loop, result hand-off
// depends on hkit_pkg
module hkit_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  hkit_pkg::t_dp_sts i_sts,
    output hkit_pkg::t_dp_cmd o_cmd,
    output logic              o_in_ready
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MOD;
                end
            end
            S_MOD: begin
                priority if (i_sts.len_zero) begin
                    o_cmd.fin_zero = 1'b1;
                    n_state        = S_EMIT;
                end else if (i_sts.mod_done) begin
                    o_cmd.rd_home = 1'b1;
                    n_state       = S_CMP;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_CMP: begin
                priority if (i_sts.slot_empty) begin
                    o_cmd.insert  = 1'b1;
                    o_cmd.fin_ins = 1'b1;
                    n_state       = S_EMIT;
                end else if (i_sts.slot_hit) begin
                    o_cmd.fin_hit = 1'b1;
                    n_state       = S_EMIT;
                end else if (i_sts.probe_last) begin
                    o_cmd.fin_full = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== hdl/hkit_dp.sv =====
// datapath: item registers, home slot reduction, slot ram, compare, count, result register
// depends on hkit_pkg and hkit_ram
module hkit_dp #(
    parameter int SLOT_COUNT  = hkit_pkg::SLOT_COUNT_DEF,
    parameter int LENGTH_BITS = hkit_pkg::LENGTH_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hkit_pkg::t_dp_cmd                   i_cmd,
    output hkit_pkg::t_dp_sts                   o_sts,
    input  logic                                i_cfg_we,
    input  logic [hkit_pkg::LOAD_LIMIT_W-1:0]   i_cfg_wdata,
    input  logic [hkit_pkg::HASH_W-1:0]         i_key_hash,
    input  logic [hkit_pkg::KEY_LEN_W-1:0]      i_key_length,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [hkit_pkg::SLOT_INDEX_W-1:0]   o_slot_index,
    output logic                                o_was_present,
    output hkit_pkg::t_status                   o_status,
    output logic                                o_load_reached
);

    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W   = (CNT_W > hkit_pkg::LOAD_LIMIT_W) ? CNT_W : hkit_pkg::LOAD_LIMIT_W;
    localparam int HASH_W  = hkit_pkg::HASH_W;
    localparam int WORD_W  = 1 + LENGTH_BITS + HASH_W;
    localparam bit IS_POW2 = ((1 << IDX_W) == SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOT_COUNT - 1);

    logic [HASH_W-1:0]      r_hash;
    logic [LENGTH_BITS-1:0] r_len;
    logic [IDX_W-1:0]       r_pos;
    logic [IDX_W-1:0]       r_probe;
    logic [IDX_W-1:0]       r_clr;
    logic [CNT_W-1:0]       r_count;
    logic [hkit_pkg::LOAD_LIMIT_W-1:0] r_load_limit;

    logic [IDX_W-1:0]       r_res_slot;
    logic                   r_res_present;
    hkit_pkg::t_status      r_res_status;

    logic                   r_out_valid;
    logic [hkit_pkg::SLOT_INDEX_W-1:0] r_slot_index;
    logic                   r_was_present;
    hkit_pkg::t_status      r_status;
    logic                   r_load_reached;

    logic [IDX_W-1:0]       home;
    logic                   mod_done;
    logic [IDX_W-1:0]       pos_next;
    logic [WORD_W-1:0]      rd_data;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [WORD_W-1:0]      wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   slot_valid;
    logic                   load_reached;

    // home slot: low bits, or a 16-bit digit remainder by reciprocal multiplication
    // for other sizes; each digit steps through load, quotient estimate, subtract and correct
    generate
        if (IS_POW2) begin : g_mask
            assign home     = r_hash[IDX_W-1:0];
            assign mod_done = 1'b1;
        end else begin : g_rem
            localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SLOT_COUNT);
            localparam logic [31:0] DIVSR = 32'(SLOT_COUNT);

            logic [IDX_W-1:0]  r_rem;
            logic [HASH_W-1:0] r_mod_sh;
            logic [2:0]        r_mod_dig;
            logic [1:0]        r_mod_ph;
            logic [31:0]       r_mod_t;
            logic [31:0]       r_mod_q;
            logic [63:0]       mod_prod;

            assign mod_prod = {32'd0, r_mod_t} * {32'd0, RECIP};

            always_ff @(posedge i_clk) begin
                if (i_cmd.accept) begin
                    r_rem     <= '0;
                    r_mod_sh  <= i_key_hash;
                    r_mod_dig <= '0;
                    r_mod_ph  <= '0;
                end else if (i_cmd.mod_step) begin
                    unique case (r_mod_ph)
                        2'd0: begin
                            r_mod_t  <= {16'(r_rem), r_mod_sh[HASH_W-1 -: 16]};
                            r_mod_sh <= {r_mod_sh[HASH_W-17:0], 16'd0};
                        end
                        2'd1: begin
                            r_mod_q <= mod_prod[63:32];
                        end
                        2'd2: begin
                            r_mod_t <= r_mod_t - r_mod_q * DIVSR;
                        end
                        2'd3: begin
                            if (r_mod_t >= DIVSR) begin
                                r_rem <= IDX_W'(r_mod_t - DIVSR);
                            end else begin
                                r_rem <= IDX_W'(r_mod_t);
                            end
                            r_mod_dig <= r_mod_dig + 3'd1;
                        end
                    endcase
                    r_mod_ph <= r_mod_ph + 2'd1;
                end
            end

            assign home     = r_rem;
            assign mod_done = r_mod_dig[2];
        end
    endgenerate

    assign pos_next = (r_pos == LAST) ? '0 : r_pos + 1'b1;

    assign wr_en   = i_cmd.clr_step | i_cmd.insert;
    assign wr_addr = i_cmd.clr_step ? r_clr : r_pos;
    assign wr_data = i_cmd.clr_step ? '0 : {1'b1, r_len, r_hash};
    assign rd_en   = i_cmd.rd_home | i_cmd.rd_next;
    assign rd_addr = i_cmd.rd_home ? home : pos_next;

    hkit_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign slot_valid = rd_data[WORD_W-1];

    assign o_sts.clr_done   = (r_clr == LAST);
    assign o_sts.len_zero   = (r_len == '0);
    assign o_sts.mod_done   = mod_done;
    assign o_sts.slot_empty = !slot_valid;
    assign o_sts.slot_hit   = slot_valid
                              && (rd_data[HASH_W +: LENGTH_BITS] == r_len)
                              && (rd_data[HASH_W-1:0] == r_hash);
    assign o_sts.probe_last = (r_probe == LAST);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign load_reached = (CMP_W'(r_count) >= CMP_W'(r_load_limit));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hash <= i_key_hash;
            r_len  <= LENGTH_BITS'(i_key_length);
        end
        if (i_cmd.rd_home) begin
            r_pos   <= home;
            r_probe <= '0;
        end else if (i_cmd.rd_next) begin
            r_pos   <= pos_next;
            r_probe <= r_probe + 1'b1;
        end
        priority if (i_cmd.fin_hit) begin
            r_res_slot    <= r_pos;
            r_res_present <= 1'b1;
            r_res_status  <= hkit_pkg::ST_OK;
        end else if (i_cmd.fin_ins) begin
            r_res_slot    <= r_pos;
            r_res_present <= 1'b0;
            r_res_status  <= hkit_pkg::ST_OK;
        end else if (i_cmd.fin_full) begin
            r_res_slot    <= '0;
            r_res_present <= 1'b0;
            r_res_status  <= hkit_pkg::ST_FULL;
        end else if (i_cmd.fin_zero) begin
            r_res_slot    <= '0;
            r_res_present <= 1'b0;
            r_res_status  <= hkit_pkg::ST_ZERO_LEN;
        end else begin
        end
        if (i_cmd.out_load) begin
            r_slot_index   <= hkit_pkg::SLOT_INDEX_W'(r_res_slot);
            r_was_present  <= r_res_present;
            r_status       <= r_res_status;
            r_load_reached <= load_reached;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr        <= '0;
            r_count      <= '0;
            r_load_limit <= hkit_pkg::LOAD_LIMIT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= (r_clr == LAST) ? '0 : r_clr + 1'b1;
            end
            if (i_cmd.insert) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cfg_we) begin
                r_load_limit <= i_cfg_wdata;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_slot_index   = r_slot_index;
    assign o_was_present  = r_was_present;
    assign o_status       = r_status;
    assign o_load_reached = r_load_reached;

endmodule

// ===== hdl/hash_keyed_intern_table_unit.sv =====
// order: accept, home slot read, probe loop, then the result goes to the output register
// throughput: one item at a time; the probe loop over the
//   slot ram reads one slot per cycle; a non power-of-two table first reduces the hash to the home slot
// reset: synchronous active low; a clearing pass writes every slot
//   with input stalled; load_limit resets to 768, entry count to zero
// top level, depends on hkit_pkg, hkit_ctrl, hkit_dp
module hash_keyed_intern_table_unit #(
    parameter int SLOT_COUNT  = hkit_pkg::SLOT_COUNT_DEF,
    parameter int LENGTH_BITS = hkit_pkg::LENGTH_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hkit_pkg::LOAD_LIMIT_W-1:0]   i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [hkit_pkg::HASH_W-1:0]         i_key_hash,
    input  logic [hkit_pkg::KEY_LEN_W-1:0]      i_key_length,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [hkit_pkg::SLOT_INDEX_W-1:0]   o_slot_index,
    output logic                                o_was_present,
    output logic [1:0]                          o_status,
    output logic                                o_load_reached
);

    hkit_pkg::t_dp_cmd cmd;
    hkit_pkg::t_dp_sts sts;
    logic              in_ready;

    hkit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    hkit_dp #(
        .SLOT_COUNT  (SLOT_COUNT),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_key_hash     (i_key_hash),
        .i_key_length   (i_key_length),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_slot_index   (o_slot_index),
        .o_was_present  (o_was_present),
        .o_status       (o_status),
        .o_load_reached (o_load_reached)
    );

    assign o_in_stall = !in_ready;

endmodule

// ===== hdl/hkit_checker.sv =====
// port-level checker for the intern table, bound to the top level
// depends on hkit_pkg and hash_keyed_intern_table_unit_assert.svh
`include "hash_keyed_intern_table_unit_assert.svh"

module hkit_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [hkit_pkg::SLOT_INDEX_W-1:0]   o_slot_index,
    input logic                                o_was_present,
    input logic [1:0]                          o_status,
    input logic                                o_load_reached
);

    `HKIT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_slot_index) && $stable(o_was_present) && $stable(o_status) && $stable(o_load_reached), "stalled item changed")
    `HKIT_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "second item taken while one is in work")
    `HKIT_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_out_valid && (o_status != hkit_pkg::ST_OK), (o_slot_index == '0) && !o_was_present, "error item carries a slot")
    `HKIT_ASSERT_IMP(a_hit_ok, i_clk, i_rst_n, o_out_valid && o_was_present, o_status == hkit_pkg::ST_OK, "hit with error status")

endmodule

bind hash_keyed_intern_table_unit hkit_checker u_hkit_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_slot_index   (o_slot_index),
    .o_was_present  (o_was_present),
    .o_status       (o_status),
    .o_load_reached (o_load_reached)
);

// ===== tb/hash_keyed_intern_table_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench for the intern table: directed and random lookups checked against a local model
// of the probe table, with random idling on both sides; depends on hkit_pkg and the unit
module hash_keyed_intern_table_unit_tb;

    localparam int SLOTS = hkit_pkg::SLOT_COUNT_DEF;

    typedef struct packed {
        logic [hkit_pkg::SLOT_INDEX_W-1:0] slot;
        logic                              present;
        hkit_pkg::t_status                 status;
        logic                              load;
    } t_intern_result;

    logic                              i_clk;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [hkit_pkg::LOAD_LIMIT_W-1:0] i_cfg_wdata = '0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [hkit_pkg::HASH_W-1:0]       i_key_hash = '0;
    logic [hkit_pkg::KEY_LEN_W-1:0]    i_key_length = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic [hkit_pkg::SLOT_INDEX_W-1:0] o_slot_index;
    logic                              o_was_present;
    logic [1:0]                        o_status;
    logic                              o_load_reached;

    // local copy of the table
    bit                                slot_used [SLOTS];
    logic [hkit_pkg::HASH_W-1:0]       slot_key_hash [SLOTS];
    logic [hkit_pkg::KEY_LEN_W-1:0]    slot_key_len [SLOTS];
    int unsigned                       entry_total = 0;
    logic [hkit_pkg::LOAD_LIMIT_W-1:0] load_limit_q = hkit_pkg::LOAD_LIMIT_RST;

    t_intern_result                    expected_results[$];
    int unsigned                       mismatch_count = 0;
    int unsigned                       idle_pct = 16;

    hash_keyed_intern_table_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_key_hash     (i_key_hash),
        .i_key_length   (i_key_length),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_slot_index   (o_slot_index),
        .o_was_present  (o_was_present),
        .o_status       (o_status),
        .o_load_reached (o_load_reached)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #150_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_intern_result predict_intern(
        input logic [hkit_pkg::HASH_W-1:0]    h,
        input logic [hkit_pkg::KEY_LEN_W-1:0] len
    );
        t_intern_result r;
        int unsigned    pos;
        int unsigned    probes;
        bit             done;
        r = '0;
        r.status = hkit_pkg::ST_ZERO_LEN;
        if (len != '0) begin
            r.status = hkit_pkg::ST_FULL;
            pos = int'(h % SLOTS);
            probes = 0;
            done = 1'b0;
            while (!done && probes < SLOTS) begin
                if (!slot_used[pos]) begin
                    slot_used[pos] = 1'b1;
                    slot_key_hash[pos] = h;
                    slot_key_len[pos] = len;
                    entry_total++;
                    r.slot = pos[hkit_pkg::SLOT_INDEX_W-1:0];
                    r.status = hkit_pkg::ST_OK;
                    done = 1'b1;
                end else if (slot_key_len[pos] == len && slot_key_hash[pos] == h) begin
                    r.slot = pos[hkit_pkg::SLOT_INDEX_W-1:0];
                    r.present = 1'b1;
                    r.status = hkit_pkg::ST_OK;
                    done = 1'b1;
                end else begin
                    pos = (pos + 1) % SLOTS;
                    probes++;
                end
            end
        end
        r.load = (entry_total >= load_limit_q);
        return r;
    endfunction

    function automatic logic [hkit_pkg::HASH_W-1:0] rand_hash();
        return {$urandom, $urandom};
    endfunction

    task automatic send_key(input logic [hkit_pkg::HASH_W-1:0] h,
                            input logic [hkit_pkg::KEY_LEN_W-1:0] len);
        int unsigned gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_key_hash <= h;
        i_key_length <= len;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_intern(h, len));
    endtask

    task automatic pick_stored(output logic [hkit_pkg::HASH_W-1:0] h,
                               output logic [hkit_pkg::KEY_LEN_W-1:0] len);
        int unsigned pos;
        pos = $urandom_range(SLOTS - 1);
        while (!slot_used[pos]) pos = $urandom_range(SLOTS - 1);
        h = slot_key_hash[pos];
        len = slot_key_len[pos];
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_load_limit(input logic [hkit_pkg::LOAD_LIMIT_W-1:0] limit);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        load_limit_q = limit;
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin
        t_intern_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: slot_index %0d status %0d", o_slot_index, o_status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_slot_index !== want.slot) begin
                    $error("slot_index: expected %0d, got %0d", want.slot, o_slot_index);
                    mismatch_count++;
                end
                if (o_was_present !== want.present) begin
                    $error("was_present: expected %0d, got %0d", want.present, o_was_present);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_load_reached !== want.load) begin
                    $error("load_reached: expected %0d, got %0d", want.load, o_load_reached);
                    mismatch_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < idle_pct);
    end

    task automatic test_zero_length();
        send_key('0, '0);
        send_key('1, '0);
    endtask

    task automatic test_field_extremes();
        send_key('0, 16'd1);
        send_key('1, 16'hFFFF);
        send_key(64'h8000_0000_0000_0000, 16'h8000);
        send_key('0, 16'd1);
        send_key('1, 16'hFFFF);
    endtask

    // home slot at the top of the table, so the probe wraps to the bottom
    task automatic test_probe_wrap();
        send_key({54'h1, 10'h3FF}, 16'd5);
        send_key({54'h1, 10'h3FF}, 16'd6);
        send_key({54'h2, 10'h3FF}, 16'd5);
        send_key({54'h1, 10'h3FF}, 16'd6);
        send_key({54'h2, 10'h3FF}, 16'd5);
    endtask

    task automatic test_load_limit_extremes();
        logic [hkit_pkg::HASH_W-1:0]    h;
        logic [hkit_pkg::KEY_LEN_W-1:0] len;
        set_load_limit('0);
        send_key(rand_hash(), '0);
        pick_stored(h, len);
        send_key(h, len);
        set_load_limit('1);
        send_key(rand_hash(), 16'd3);
        send_key(rand_hash(), '0);
        set_load_limit(11'd1);
        send_key(rand_hash(), 16'd7);
        set_load_limit(11'd1024);
        send_key(rand_hash(), 16'd9);
    endtask

    task automatic run_mixed_traffic(input int unsigned count);
        logic [hkit_pkg::HASH_W-1:0]    h;
        logic [hkit_pkg::KEY_LEN_W-1:0] len;
        int unsigned                    sel;
        for (int unsigned i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 5) begin
                send_key(rand_hash(), '0);
            end else if (sel < 50 && entry_total > 0) begin
                pick_stored(h, len);
                send_key(h, len);
            end else if (sel < 54 && entry_total > 0) begin
                pick_stored(h, len);
                send_key(h, len + 16'($urandom_range(1, 3)));
            end else if (sel < 66) begin
                h = rand_hash();
                h[hkit_pkg::SLOT_INDEX_W-1:0] =
                    hkit_pkg::SLOT_INDEX_W'(1016 + $urandom_range(0, 15));
                send_key(h, 16'($urandom_range(1, 65535)));
            end else begin
                send_key(rand_hash(), 16'($urandom_range(1, 65535)));
            end
        end
    endtask

    task automatic test_random_traffic();
        set_load_limit(11'($urandom_range(1, 1024)));
        run_mixed_traffic(400);
        idle_pct = 0;
        run_mixed_traffic(400);
        idle_pct = 16;
        set_load_limit(11'($urandom_range(400, 900)));
        run_mixed_traffic(200);
        drain_results();
        run_mixed_traffic(200);
        set_load_limit(11'($urandom_range(1, 1024)));
        run_mixed_traffic(400);
    endtask

    task automatic test_full_table();
        logic [hkit_pkg::HASH_W-1:0]    h;
        logic [hkit_pkg::KEY_LEN_W-1:0] len;
        set_load_limit(11'd1024);
        while (entry_total < SLOTS) send_key(rand_hash(), 16'($urandom_range(1, 65535)));
        repeat (4) send_key(rand_hash(), 16'($urandom_range(1, 65535)));
        repeat (6) begin
            pick_stored(h, len);
            send_key(h, len);
        end
        send_key(rand_hash(), '0);
        set_load_limit('1);
        send_key(rand_hash(), 16'd1);
        pick_stored(h, len);
        send_key(h, len);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_zero_length();
        test_field_extremes();
        test_probe_wrap();
        test_load_limit_extremes();
        test_random_traffic();
        test_full_table();
        drain_results();
        repeat (32) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/hkit_pkg.sv
hdl/hkit_ram.sv
hdl/hkit_ctrl.sv
hdl/hkit_dp.sv
hdl/hash_keyed_intern_table_unit.sv
hdl/hkit_checker.sv
tb/hash_keyed_intern_table_unit_tb.sv
